### src/ipps_pkg.sv
// Shared types and constants of the injector pulse pattern sequencer.
// No dependencies; every file but ipps_ram imports this package.
`default_nettype none
package ipps_pkg;

  localparam int OPC_W    = 2;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 8;
  localparam int MASK_W   = 8;
  localparam int ACT_W    = 4;
  localparam int PHASE_W  = 2;
  localparam int TIME_W   = 16;
  localparam int INJ_W    = 4;
  localparam int LEN_W    = 5;
  localparam int RPT_W    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INJ_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 3'd4;

  localparam logic [TIME_W-1:0] PULSE_MS_RST = 16'd10;
  localparam logic [TIME_W-1:0] GAP_MS_RST   = 16'd100;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } opcode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  // Live configuration seen by the sequencer
  typedef struct packed {
    logic [TIME_W-1:0] pulse_ms;
    logic [TIME_W-1:0] gap_ms;
    logic [INJ_W-1:0]  inj_count;
    logic [LEN_W-1:0]  pat_len;
    logic [RPT_W-1:0]  repeat_count;
  } cfg_t;

  // Classified command handed from the front end to the sequencer
  typedef struct packed {
    opcode_t          op;
    logic             wr_ok;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

### src/ipps_if.sv
// Channel interfaces: command input, status result output, configuration writes.
// Depends on ipps_pkg for field widths.
`default_nettype none
interface ipps_in_if import ipps_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [IDX_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;

  modport source (output valid, output opcode, output entry_index, output entry_value,
                  input ready);
  modport sink   (input valid, input opcode, input entry_index, input entry_value,
                  output ready);
endinterface

interface ipps_out_if import ipps_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  drive_mask;
  logic               running;
  logic [PHASE_W-1:0] phase;
  logic [ACT_W-1:0]   active_injector;

  modport source (output valid, output drive_mask, output running, output phase,
                  output active_injector, input ready);
  modport sink   (input valid, input drive_mask, input running, input phase,
                  input active_injector, output ready);
endinterface

interface ipps_cfg_if import ipps_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/ipps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ipps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/ipps_front.sv
// Front end: accepts input items, classifies them and queues them for the sequencer.
// Depends on ipps_pkg and ipps_if.
`default_nettype none
module ipps_front import ipps_pkg::*; #(
  parameter int PATTERN_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ipps_in_if.sink   in_chan,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_pop
);

  cmd_t       q_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_chan.ready = (count_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (count_r != 2'd0);
  assign cmd           = q_r[head_r];

  // Flag writes that land inside the pattern store
  always_comb begin
    cmd_in.op    = opcode_t'(in_chan.opcode);
    cmd_in.wr_ok = (in_chan.opcode == OP_WRITE) &&
                   (32'(in_chan.entry_index) < PATTERN_DEPTH);
    cmd_in.idx   = in_chan.entry_index;
    cmd_in.value = in_chan.entry_value;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = ~tail_r;
    end
    if (cmd_pop) begin
      head_nxt = ~head_r;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

### src/ipps_back.sv
// Back end: pulse/gap timing, pattern walk over the store RAM and the result register.
// Depends on ipps_pkg, ipps_if and ipps_ram.
`default_nettype none
module ipps_back import ipps_pkg::*; #(
  parameter int PATTERN_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  ipps_out_if.source out_chan
);

  localparam int ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_CHECK, ST_EMIT} state_t;

  state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]         position_r, position_nxt;
  logic [LEN_W-1:0]         seen_r, seen_nxt;
  logic [RPT_W-1:0]         repeats_r, repeats_nxt;
  phase_t                   phase_r, phase_nxt;
  logic                     running_r, running_nxt;
  logic [ACT_W-1:0]         active_r, active_nxt;
  logic [TIME_W-1:0]        time_r, time_nxt;
  logic [PATTERN_DEPTH-1:0] filled_r, filled_nxt;
  logic                     filled_q_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]        out_mask_r, out_mask_nxt;
  logic                     out_running_r, out_running_nxt;
  logic [PHASE_W-1:0]       out_phase_r, out_phase_nxt;
  logic [ACT_W-1:0]         out_active_r, out_active_nxt;

  logic                     pos_wrap;
  logic [LEN_W-1:0]         pos_eff;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     ram_we;
  logic [VAL_W-1:0]         ram_rdata;
  logic [VAL_W-1:0]         entry;
  logic                     entry_ok;
  logic [MASK_W-1:0]        mask;

  assign pos_wrap = (position_r >= cfg.pat_len);
  assign pos_eff  = pos_wrap ? '0 : position_r;
  assign rd_addr  = ADDR_W'(pos_eff);
  assign wr_addr  = ADDR_W'(cmd.idx);
  assign entry    = filled_q_r ? ram_rdata : '0;
  assign entry_ok = (entry != '0) && (entry <= VAL_W'(cfg.inj_count));

  ipps_ram #(.WIDTH(VAL_W), .DEPTH(PATTERN_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (cmd.value),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      mask[k] = (phase_r == PH_PULSE) && (active_r == ACT_W'(k + 1));
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.drive_mask      = out_mask_r;
  assign out_chan.running         = out_running_r;
  assign out_chan.phase           = out_phase_r;
  assign out_chan.active_injector = out_active_r;

  always_comb begin
    state_nxt       = state_r;
    position_nxt    = position_r;
    seen_nxt        = seen_r;
    repeats_nxt     = repeats_r;
    phase_nxt       = phase_r;
    running_nxt     = running_r;
    active_nxt      = active_r;
    time_nxt        = time_r;
    filled_nxt      = filled_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_mask_nxt    = out_mask_r;
    out_running_nxt = out_running_r;
    out_phase_nxt   = out_phase_r;
    out_active_nxt  = out_active_r;
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          state_nxt = ST_EMIT;
          unique case (cmd.op)
            OP_TICK: begin
              if (running_r) begin
                if (time_r > TIME_W'(1)) begin
                  time_nxt = time_r - TIME_W'(1);
                end else if (phase_r == PH_PULSE) begin
                  phase_nxt = PH_GAP;
                  time_nxt  = cfg.gap_ms;
                end else begin
                  seen_nxt  = '0;
                  state_nxt = ST_STEP;
                end
              end
            end
            OP_WRITE: begin
              if (cmd.wr_ok) begin
                ram_we              = 1'b1;
                filled_nxt[wr_addr] = 1'b1;
              end
            end
            OP_START: begin
              position_nxt = '0;
              repeats_nxt  = cfg.repeat_count;
              running_nxt  = 1'b1;
              phase_nxt    = PH_IDLE;
              active_nxt   = '0;
              seen_nxt     = '0;
              state_nxt    = ST_STEP;
            end
            OP_STOP: begin
              running_nxt = 1'b0;
              phase_nxt   = PH_IDLE;
              active_nxt  = '0;
              time_nxt    = '0;
            end
            default: ;
          endcase
        end
      end

      ST_STEP: begin
        if ((cfg.inj_count == '0) || (seen_r >= cfg.pat_len)) begin
          running_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
          active_nxt  = '0;
          time_nxt    = '0;
          state_nxt   = ST_EMIT;
        end else if (pos_wrap && (cfg.repeat_count != '0) && (repeats_r <= RPT_W'(1))) begin
          // Last pass used up: stop
          repeats_nxt  = '0;
          position_nxt = '0;
          running_nxt  = 1'b0;
          phase_nxt    = PH_IDLE;
          active_nxt   = '0;
          time_nxt     = '0;
          state_nxt    = ST_EMIT;
        end else begin
          if (pos_wrap && (cfg.repeat_count != '0)) begin
            repeats_nxt = repeats_r - RPT_W'(1);
          end
          position_nxt = pos_eff + LEN_W'(1);
          seen_nxt     = seen_r + LEN_W'(1);
          state_nxt    = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (entry_ok) begin
          active_nxt = ACT_W'(entry);
          phase_nxt  = PH_PULSE;
          time_nxt   = cfg.pulse_ms;
          state_nxt  = ST_EMIT;
        end else begin
          state_nxt = ST_STEP;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_mask_nxt    = mask;
          out_running_nxt = running_r;
          out_phase_nxt   = phase_r;
          out_active_nxt  = active_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      position_r    <= '0;
      seen_r        <= '0;
      repeats_r     <= '0;
      phase_r       <= PH_IDLE;
      running_r     <= 1'b0;
      active_r      <= '0;
      time_r        <= '0;
      filled_r      <= '0;
      filled_q_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_mask_r    <= '0;
      out_running_r <= 1'b0;
      out_phase_r   <= PH_IDLE;
      out_active_r  <= '0;
    end else begin
      state_r       <= state_nxt;
      position_r    <= position_nxt;
      seen_r        <= seen_nxt;
      repeats_r     <= repeats_nxt;
      phase_r       <= phase_nxt;
      running_r     <= running_nxt;
      active_r      <= active_nxt;
      time_r        <= time_nxt;
      filled_r      <= filled_nxt;
      filled_q_r    <= filled_r[rd_addr];
      out_valid_r   <= out_valid_nxt;
      out_mask_r    <= out_mask_nxt;
      out_running_r <= out_running_nxt;
      out_phase_r   <= out_phase_nxt;
      out_active_r  <= out_active_nxt;
    end
  end

endmodule
`default_nettype wire

### src/injector_pulse_pattern_sequencer.sv
// Top level of the injector pulse pattern sequencer: configuration registers,
// front end, sequencer back end. Depends on ipps_pkg, ipps_if, ipps_front, ipps_back.
//
//  channel   dir  handshake            payload
//  in_chan   in   valid/ready          opcode, entry_index, entry_value
//  out_chan  out  valid/ready          drive_mask, running, phase, active_injector
//  cfg_chan  in   valid/ready (ready=1) index, data
//
// Sequencing: tick, write and stop items go from idle to the result register; start,
//   and a tick that ends a gap, walk the pattern first: a step and a check state per
//   entry visited, with one registered RAM read each, and a final step when the walk
//   stops the block. A new item is taken only once the last result is registered.
// Reset: synchronous, active low; loads configuration reset values, clears state and
//   entry valid bits, so unwritten pattern entries read as zero. No clearing pass.
// Stalls: a two-entry queue decouples input from the sequencer; the result register
//   holds until out_chan.ready, and input fills the queue meanwhile until it is full.
`default_nettype none
module injector_pulse_pattern_sequencer import ipps_pkg::*; #(
  parameter int PATTERN_DEPTH = 16,
  parameter int MAX_INJECTORS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ipps_in_if.sink    in_chan,
  ipps_out_if.source out_chan,
  ipps_cfg_if.sink   cfg_chan
);

  cfg_t cfg_r, cfg_nxt;
  logic cfg_xfer;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Always take configuration; the user must write only while the block is idle, the block does not enforce it
  assign cfg_chan.ready = 1'b1;
  assign cfg_xfer       = cfg_chan.valid && cfg_chan.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_xfer) begin
      unique case (cfg_chan.index)
        CFG_PULSE_MS: begin
          // drop zero lengths
          if (cfg_chan.data != '0) begin
            cfg_nxt.pulse_ms = cfg_chan.data;
          end
        end
        CFG_GAP_MS: begin
          if (cfg_chan.data != '0) begin
            cfg_nxt.gap_ms = cfg_chan.data;
          end
        end
        CFG_INJ_COUNT: begin
          // clamp to the injectors the block can drive
          if (32'(cfg_chan.data[INJ_W-1:0]) > MAX_INJECTORS) begin
            cfg_nxt.inj_count = INJ_W'(MAX_INJECTORS);
          end else begin
            cfg_nxt.inj_count = cfg_chan.data[INJ_W-1:0];
          end
        end
        CFG_PATTERN_LEN: begin
          // clamp to the pattern store depth
          if (32'(cfg_chan.data[LEN_W-1:0]) > PATTERN_DEPTH) begin
            cfg_nxt.pat_len = LEN_W'(PATTERN_DEPTH);
          end else begin
            cfg_nxt.pat_len = cfg_chan.data[LEN_W-1:0];
          end
        end
        CFG_REPEAT_COUNT: begin
          cfg_nxt.repeat_count = cfg_chan.data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ms     <= PULSE_MS_RST;
      cfg_r.gap_ms       <= GAP_MS_RST;
      cfg_r.inj_count    <= '0;
      cfg_r.pat_len      <= '0;
      cfg_r.repeat_count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept and classify items
  ipps_front #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Run the pattern and produce one result per item
  ipps_back #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan)
  );

  // At most one injector driven in any result
  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> $onehot0(out_chan.drive_mask))
    else $error("drive_mask has more than one injector on");

  // Drive only during a pulse, and a stopped block shows nothing selected
  a_mask_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.phase != PH_PULSE) |-> (out_chan.drive_mask == '0))
    else $error("drive_mask set outside a pulse");

  a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.running |->
      (out_chan.phase == PH_IDLE) && (out_chan.active_injector == '0))
    else $error("stopped result shows an active injector");

  // Zero pulse lengths are ignored
  a_pulse_zero_kept: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_xfer && (cfg_chan.index == CFG_PULSE_MS) && (cfg_chan.data == '0)
      |=> $stable(cfg_r.pulse_ms))
    else $error("zero pulse length was written");

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking bench for injector_pulse_pattern_sequencer: directed and random command
// traffic against an in-bench prediction of the sequencer, with random back-pressure.
// Depends on ipps_pkg, the ipps_*_if interfaces and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
  import ipps_pkg::*;

  localparam int DEPTH     = 16;
  localparam int MAX_INJ   = 8;
  localparam int PHASES    = 12;
  localparam int PHASE_LEN = 104;
  localparam int TAIL      = 80;        // margin over the longest pattern walk
  localparam int LONG_HOLD = 400;
  localparam int LIMIT     = 1000000;
  localparam int MAX_REPORTS = 200;

  // Register index outside the map; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    opcode_t          op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } inj_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              running;
    phase_t            phase;
    logic [ACT_W-1:0]  act;
  } inj_status_t;

  logic clk = 1'b0;
  logic rst_n;

  ipps_in_if  in_chan ();
  ipps_out_if out_chan ();
  ipps_cfg_if cfg_chan ();

  injector_pulse_pattern_sequencer #(
    .PATTERN_DEPTH(DEPTH),
    .MAX_INJECTORS(MAX_INJ)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #6 clk = ~clk;

  // Commands waiting to transfer, and the status each transferred command should produce
  inj_cmd_t    cmd_q[$];
  inj_status_t status_q[$];

  int err_cnt   = 0;
  int cycle_cnt = 0;

  // ---------------------------------------------------------------------------
  // Sequencer prediction: live copy of the registers and of the sequencer state
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] cf_pulse;
  logic [TIME_W-1:0] cf_gap;
  int                cf_inj;
  int                cf_len;
  logic [RPT_W-1:0]  cf_rpt;

  logic [VAL_W-1:0]  seq_pattern [DEPTH];
  int                seq_pos;
  int                seq_reps;
  phase_t            seq_phase;
  logic              seq_run;
  logic [ACT_W-1:0]  seq_act;
  logic [TIME_W-1:0] seq_left;

  function automatic void seq_halt();
    seq_run   = 1'b0;
    seq_phase = PH_IDLE;
    seq_act   = '0;
    seq_left  = '0;
  endfunction

  // Walk from the current position to the next usable entry and open its pulse.
  // Wrapping costs one repeat when a repeat count is set; a fruitless pass stops.
  function automatic void seq_select();
    int seen;
    logic [VAL_W-1:0] v;
    seen = 0;
    if (cf_len == 0 || cf_inj == 0) begin
      seq_halt();
      return;
    end
    while (seen < cf_len) begin
      if (seq_pos >= cf_len) begin
        seq_pos = 0;
        if (cf_rpt != 0) begin
          if (seq_reps <= 1) begin
            seq_reps = 0;
            seq_halt();
            return;
          end
          seq_reps--;
        end
      end
      v = (seq_pos < DEPTH) ? seq_pattern[seq_pos] : '0;
      seq_pos++;
      seen++;
      if (v != 0 && v <= cf_inj) begin
        seq_act   = ACT_W'(v);
        seq_phase = PH_PULSE;
        seq_left  = cf_pulse;
        return;
      end
    end
    seq_halt();
  endfunction

  function automatic inj_status_t seq_step(inj_cmd_t c);
    inj_status_t r;
    case (c.op)
      OP_TICK: begin
        if (seq_run) begin
          if (seq_left > 1) begin
            seq_left--;
          end else if (seq_phase == PH_PULSE) begin
            seq_phase = PH_GAP;
            seq_left  = cf_gap;
          end else begin
            seq_select();
          end
        end
      end
      OP_WRITE: seq_pattern[c.idx] = c.val;
      OP_START: begin
        seq_pos   = 0;
        seq_reps  = cf_rpt;
        seq_run   = 1'b1;
        seq_phase = PH_IDLE;
        seq_act   = '0;
        seq_select();
      end
      default: seq_halt();
    endcase
    r.mask    = (seq_phase == PH_PULSE && seq_act != 0) ? (8'd1 << (seq_act - 4'd1)) : '0;
    r.running = seq_run;
    r.phase   = seq_phase;
    r.act     = seq_act;
    return r;
  endfunction

  function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PULSE_MS:     if (data != 0) cf_pulse = data;
      CFG_GAP_MS:       if (data != 0) cf_gap = data;
      CFG_INJ_COUNT:    cf_inj = (data[INJ_W-1:0] > MAX_INJ) ? MAX_INJ : int'(data[INJ_W-1:0]);
      CFG_PATTERN_LEN:  cf_len = (data[LEN_W-1:0] > DEPTH) ? DEPTH : int'(data[LEN_W-1:0]);
      CFG_REPEAT_COUNT: cf_rpt = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps (tx_bursty)
  // ---------------------------------------------------------------------------
  bit in_taken  = 1'b0;
  bit tx_bursty = 1'b0;
  int tx_gap    = 0;
  int tx_burst  = 1;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid       <= 1'b0;
      in_chan.opcode      <= '0;
      in_chan.entry_index <= '0;
      in_chan.entry_value <= '0;
    end else if (in_chan.valid && !in_taken) begin
      // hold the offer until it transfers
    end else if (tx_gap != 0) begin
      in_chan.valid <= 1'b0;
      tx_gap        <= tx_gap - 1;
    end else if (cmd_q.size() != 0) begin
      in_chan.valid       <= 1'b1;
      in_chan.opcode      <= cmd_q[0].op;
      in_chan.entry_index <= cmd_q[0].idx;
      in_chan.entry_value <= cmd_q[0].val;
      // close the burst after this command and pick the gap that follows it
      if (tx_burst <= 1) begin
        tx_burst <= $urandom_range(1, 24);
        if (!tx_bursty)
          tx_gap <= 0;
        else if ($urandom_range(0, 9) == 0)
          tx_gap <= $urandom_range(8, 30);
        else
          tx_gap <= $urandom_range(0, 3);
      end else begin
        tx_burst <= tx_burst - 1;
      end
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: free, random or a rotating pattern; a long hold overrides all three
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode     = RX_FREE;
  logic [15:0] rx_pat      = 16'h00ff;
  logic [3:0]  rx_ph       = '0;
  bit          rx_hold     = 1'b0;
  bit          rx_hold_req = 1'b0;

  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_chan.ready <= 1'b1;
        RX_RANDOM: out_chan.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_chan.ready <= rx_pat[rx_ph];
          rx_ph          <= rx_ph + 4'd1;
        end
      endcase
    end
  end

  // Hold off the result side for a long stretch once asked to; count it here
  initial begin : long_hold
    while (!rx_hold_req) @(posedge clk);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the result transfer first, then predict the command transfer
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, logic [31:0] want, logic [31:0] seen);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $error("%s mismatch: expected %0h, got %0h", field, want, seen);
  endtask

  always @(posedge clk) begin
    inj_status_t want_st;
    inj_cmd_t    taken;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (status_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $error("status transfer with nothing expected: mask %0h running %0b",
                 out_chan.drive_mask, out_chan.running);
      end else begin
        want_st = status_q.pop_front();
        if (out_chan.drive_mask !== want_st.mask)
          report_field("drive_mask", want_st.mask, out_chan.drive_mask);
        if (out_chan.running !== want_st.running)
          report_field("running", want_st.running, out_chan.running);
        if (out_chan.phase !== want_st.phase)
          report_field("phase", want_st.phase, out_chan.phase);
        if (out_chan.active_injector !== want_st.act)
          report_field("active_injector", want_st.act, out_chan.active_injector);
      end
    end
    in_taken = rst_n && in_chan.valid && in_chan.ready;
    if (in_taken) begin
      taken.op  = opcode_t'(in_chan.opcode);
      taken.idx = in_chan.entry_index;
      taken.val = in_chan.entry_value;
      status_q.push_back(seq_step(taken));
      void'(cmd_q.pop_front());
    end
  end

  // Watchdog: a run that hangs ends as a failure
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(opcode_t op, int idx, int val);
    inj_cmd_t c;
    c.op  = op;
    c.idx = IDX_W'(idx);
    c.val = VAL_W'(val);
    cmd_q.push_back(c);
  endfunction

  // Mostly usable injector numbers, with zeros, one past the count and wild values
  function automatic int pick_injector();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, 255);
      2:       return cf_inj + 1;
      default: return $urandom_range(1, (cf_inj > 0) ? cf_inj : 1);
    endcase
  endfunction

  // Mostly slots inside the active pattern, sometimes anywhere in the store
  function automatic int pick_slot();
    if (cf_len > 0 && $urandom_range(0, 3) != 0)
      return $urandom_range(0, cf_len - 1);
    return $urandom_range(0, DEPTH - 1);
  endfunction

  // Mostly well-formed runs: load a few entries, start, then tick through pulses,
  // gaps and wraps. The rest is noise and bare tick strings.
  function automatic void gen_traffic(int n);
    int made;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          queue_cmd(opcode_t'($urandom_range(0, 3)), $urandom, $urandom);
          made++;
        end
        2: begin
          repeat ($urandom_range(1, 12)) begin
            queue_cmd(OP_TICK, $urandom, $urandom);
            made++;
          end
        end
        default: begin
          repeat ($urandom_range(0, 4)) begin
            queue_cmd(OP_WRITE, pick_slot(), pick_injector());
            made++;
          end
          queue_cmd(OP_START, $urandom, $urandom);
          made++;
          repeat ($urandom_range(4, 40)) begin
            if ($urandom_range(0, 19) == 0)
              queue_cmd(OP_WRITE, pick_slot(), pick_injector());
            else
              queue_cmd(OP_TICK, $urandom, $urandom);
            made++;
          end
          if ($urandom_range(0, 7) == 0) begin
            queue_cmd(OP_STOP, $urandom, $urandom);
            made++;
          end
        end
      endcase
    end
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_apply(idx, data);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic configure(int pulse, int gap, int inj, int len, int rpt);
    cfg_write(CFG_PULSE_MS, CFG_DATA_W'(pulse));
    cfg_write(CFG_GAP_MS, CFG_DATA_W'(gap));
    cfg_write(CFG_INJ_COUNT, CFG_DATA_W'(inj));
    cfg_write(CFG_PATTERN_LEN, CFG_DATA_W'(len));
    cfg_write(CFG_REPEAT_COUNT, CFG_DATA_W'(rpt));
  endtask

  // Wait until every queued command is sent and every expected status is back, then let the block settle
  task automatic drain();
    while (cmd_q.size() != 0 || status_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int pulse, gap, inj, len, rpt;

    // park the configuration inputs and hold reset low for a while; the sender and
    // receiver idle their own signals while reset is low
    rst_n                = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = '0;
    cfg_chan.data        = '0;

    cf_pulse = PULSE_MS_RST;
    cf_gap   = GAP_MS_RST;
    cf_inj   = 0;
    cf_len   = 0;
    cf_rpt   = '0;
    foreach (seq_pattern[i]) seq_pattern[i] = '0;
    seq_pos  = 0;
    seq_reps = 0;
    seq_halt();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle tick, start with nothing configured, stop, store extremes
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_START, 15, 255);
    queue_cmd(OP_STOP, 0, 0);
    queue_cmd(OP_WRITE, 15, 255);
    queue_cmd(OP_WRITE, 0, 1);
    drain();

    // Longest pulse and gap; oversized count and length clamp; zero and spare writes drop
    configure(65535, 65535, 16'h00ff, 16'hffff, 65535);
    cfg_write(CFG_PULSE_MS, '0);
    cfg_write(CFG_GAP_MS, '0);
    cfg_write(CFG_SPARE, 16'hffff);
    queue_cmd(OP_WRITE, 1, 8);
    queue_cmd(OP_WRITE, 2, 9);      // above the injector count, skipped
    queue_cmd(OP_START, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_WRITE, 3, 0);      // write while running
    queue_cmd(OP_START, 0, 0);      // restart while running
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_STOP, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    drain();

    // Shortest timing, one pass: repeats run out at the wrap; then a pass with no valid entry
    configure(1, 1, 1, 2, 1);
    queue_cmd(OP_START, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_TICK, 0, 0);
    queue_cmd(OP_WRITE, 0, 0);
    queue_cmd(OP_START, 0, 0);
    queue_cmd(OP_WRITE, 0, 1);
    drain();

    // Random phases; the sequencer may still be running when new settings land
    for (int ph = 0; ph < PHASES; ph++) begin
      tx_bursty = (ph % 4 != 0);
      rx_mode   = rx_mode_t'(ph % 3);
      rx_pat    = 16'($urandom) | 16'h0001;

      pulse = $urandom_range(1, 4);
      gap   = $urandom_range(1, 4);
      inj   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, MAX_INJ);
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = DEPTH;
        default: len = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       rpt = 65535;
        1, 2, 3: rpt = $urandom_range(1, 3);
        default: rpt = 0;
      endcase
      if (ph == PHASES - 1) begin
        inj = MAX_INJ;
        len = DEPTH;
        rpt = 65535;
      end
      configure(pulse, gap, inj, len, rpt);

      // back up the result side while the sender keeps pushing, so input stalls
      if (ph == 4) begin
        tx_bursty   = 1'b0;
        rx_hold_req = 1'b1;
      end
      gen_traffic(PHASE_LEN);
      drain();
    end

    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
